/* sv/signed_int_to_decimal_ascii_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text block
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SITDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sitda: implication check failed");
// next-cycle implication
`define SITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sitda: next-cycle check failed");
`else
`define SITDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sitda_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int INPUT_WIDTH         = 64;  // width of the value port
	localparam int DEFAULT_VALUE_WIDTH = 64;  // bits of value actually used
	localparam int QUEUE_DEPTH         = 2;   // items between front and back

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	// double dabble: a BCD digit of 5 or more gets 3 added before the shift
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage
`default_nettype wire

/* sv/sitda_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_queue
// Short FIFO that decouples the front (classify) from the back (convert).
// ----------------------------------------------------------------------------
module sitda_queue #(
	parameter int WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import sitda_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/sitda_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_front
// Takes items, splits each value into sign and exact unsigned magnitude.
// ----------------------------------------------------------------------------
module sitda_front #(
	parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic signed [sitda_pkg::INPUT_WIDTH-1:0] value,
	output logic                                full,
	output logic                                q_push,
	output logic [VALUE_WIDTH:0]                q_item,
	input  logic                                q_full
);
	import sitda_pkg::*;

	logic [VALUE_WIDTH-1:0] raw_s1;
	logic                   valid_s1;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;

	// negating in W bits gives the exact magnitude, most negative included
	assign neg    = raw_s1[VALUE_WIDTH-1];
	assign mag    = neg ? ({VALUE_WIDTH{1'b0}} - raw_s1) : raw_s1;
	assign q_item = {neg, mag};

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= value[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* sv/sitda_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_back
// Bit-serial double dabble, then emits sign and digits through an output reg.
// ----------------------------------------------------------------------------
module sitda_back #(
	parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  logic [VALUE_WIDTH:0] q_item,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           char_code,
	output logic                 is_last
);
	import sitda_pkg::*;

	// decimal digits of 2^(W-1), the largest magnitude
	localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int IW   = $clog2(NDIG);
	localparam int CW   = $clog2(NDIG + 1);
	localparam int BW   = $clog2(VALUE_WIDTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [NDIG*4-1:0]      bcd_q;
	logic [CW-1:0]          cnt_q;
	logic [BW-1:0]          bits_q;
	logic                   neg_q;
	logic                   sign_pend_q;
	logic [IW-1:0]          pos_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	logic [NDIG*4-1:0]      bcd_adj;
	logic [NDIG*4-1:0]      bcd_nx;
	logic [CW-1:0]          cnt_nx;
	logic [3:0]             top_dig;
	logic [3:0]             emit_dig;
	logic                   slot_free;
	logic                   load_out;

	assign empty     = !out_valid_q;
	assign char_code = char_q;
	assign is_last   = last_q;
	assign slot_free = !out_valid_q || pop;
	assign load_out  = slot_free && (state_q == ST_EMIT);
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;

	// one double dabble step: adjust every digit, shift in the next bit
	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			bcd_adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= BCD_ADJ_MIN) ?
				bcd_q[d*4 +: 4] + BCD_ADJ_ADD : bcd_q[d*4 +: 4];
		end
		bcd_nx = {bcd_adj[NDIG*4-2:0], mag_q[VALUE_WIDTH-1]};
	end

	// digit count grows by at most one per step
	assign top_dig = bcd_nx[cnt_q[IW-1:0]*4 +: 4];
	assign cnt_nx  = ((cnt_q < CW'(NDIG)) && (top_dig != 4'd0)) ? cnt_q + 1'b1 : cnt_q;

	assign emit_dig = bcd_q[pos_q*4 +: 4];

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					neg_q <= q_item[VALUE_WIDTH];
					mag_q <= q_item[VALUE_WIDTH-1:0];
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= bcd_nx;
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			end
			default: begin
			end
		endcase
		if (load_out) begin
			if (sign_pend_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {4'd0, emit_dig};
				last_q <= (pos_q == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			bits_q      <= '0;
			sign_pend_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new character replaces the one popped in the same cycle
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= '0;
						bits_q  <= BW'(VALUE_WIDTH);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q  <= cnt_nx;
					bits_q <= bits_q - 1'b1;
					if (bits_q == BW'(1)) begin
						// zero still prints one digit
						pos_q       <= (cnt_nx == '0) ? '0 : IW'(cnt_nx - 1'b1);
						sign_pend_q <= neg_q;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer in, decimal ASCII text out
// The back end converts one item at a time through the one-bit-per-cycle
// double dabble loop, then emits sign and digits; it takes no new item
// until the last character of the current one is loaded into the output.
// Reset (arst_n low) empties all stages at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"
module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	output logic                                     full,
	input  logic signed [sitda_pkg::INPUT_WIDTH-1:0] value,
	output logic                                     empty,
	input  logic                                     pop,
	output logic [7:0]                               char_code,
	output logic                                     is_last
);
	import sitda_pkg::*;

	// front -> queue: classified item is {sign, magnitude}
	logic                 fq_push;
	logic [VALUE_WIDTH:0] fq_item;
	logic                 fq_full;

	// queue -> back
	logic                 qb_pop;
	logic [VALUE_WIDTH:0] qb_item;
	logic                 qb_empty;

	// kinds of character on the output, for the checks below
	logic                 out_is_minus;
	logic                 out_is_digit;

	assign out_is_minus = (char_code == ASCII_MINUS);
	assign out_is_digit = (char_code >= ASCII_ZERO) && (char_code <= ASCII_ZERO + 8'd9);

	// Front: one register stage that takes an item whenever it is free or
	// draining into the queue, and forms sign and exact magnitude.
	sitda_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.value  (value),
		.full   (full),
		.q_push (fq_push),
		.q_item (fq_item),
		.q_full (fq_full)
	);

	// Short queue so the front keeps taking items while the back converts.
	sitda_queue #(
		.WIDTH(VALUE_WIDTH + 1)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_item),
		.full   (fq_full),
		.pop    (qb_pop),
		.rdata  (qb_item),
		.empty  (qb_empty)
	);

	// Back: shift-add-3 conversion over every magnitude bit, then one character
	// per cycle into an output register that pop drains, whenever it is empty or being popped.
	sitda_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (qb_empty),
		.q_item    (qb_item),
		.q_pop     (qb_pop),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.is_last   (is_last)
	);

	// Every shown item is a minus sign or a decimal digit.
	`SITDA_ASSERT_IMP(a_char_legal, clk, arst_n, !empty, out_is_minus || out_is_digit)
	// The text never ends on the minus sign.
	`SITDA_ASSERT_IMP(a_last_is_digit, clk, arst_n, !empty && is_last, !out_is_minus)
	// A minus sign is always followed by a digit of the same number.
	`SITDA_ASSERT_NEXT(a_minus_then_digit, clk, arst_n, !empty && pop && out_is_minus, empty || !out_is_minus)
	// The front only stalls when the queue behind it is full.
	`SITDA_ASSERT_IMP(a_full_from_queue, clk, arst_n, full, fq_full)

endmodule
`default_nettype wire
